// ----- rtl/core/vbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_pkg
// Shared types, constants and helper functions for the beep sequencer.
// ----------------------------------------------------------------------------
package vbs_pkg;

    localparam int unsigned HZ_W    = 15;
    localparam int unsigned MS_W    = 12;
    localparam int unsigned CNT_W   = 16;
    localparam int unsigned VOL_W   = 3;
    localparam int unsigned PIN_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 3;

    // tone timer base clock in Hz, also the divider dividend
    localparam logic [HZ_W-1:0] TONE_CLK_HZ = 15'd31250;
    localparam logic [MS_W-1:0] MS_MAX      = 12'd2113;
    localparam int unsigned     DIV_STEPS   = HZ_W;
    localparam int unsigned     DIV_CNT_W   = $clog2(DIV_STEPS);

    // action codes
    localparam logic [1:0] ACT_TICK     = 2'd0;
    localparam logic [1:0] ACT_UPDATE   = 2'd1;
    localparam logic [1:0] ACT_OVERRIDE = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLUID  = 2'd1;

    localparam logic [VOL_W-1:0] VOL_RESET = 3'd2;
    localparam logic [VOL_W-1:0] VOL_MAX   = 3'd4;

    // pin pairs, bit0..3 = A..D
    localparam logic [PIN_W-1:0] PINS_AD = 4'h9;
    localparam logic [PIN_W-1:0] PINS_AC = 4'h5;
    localparam logic [PIN_W-1:0] PINS_BD = 4'hA;
    localparam logic [PIN_W-1:0] PINS_BC = 4'h6;
    localparam logic [PIN_W-1:0] PINS_OFF = 4'h0;

    typedef struct packed {
        logic [1:0]      action;
        logic [HZ_W-1:0] tone_hz;
        logic [MS_W-1:0] length_ms;
        logic [MS_W-1:0] pause_ms;
    } t_in_item;

    typedef struct packed {
        logic             speaker_level;
        logic [PIN_W-1:0] pin_drive;
        logic             pause_phase;
        logic             pulsed;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_APPLY,
        S_EMIT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic div_start;
        logic apply;
        logic emit;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic needs_div;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [PIN_W-1:0] vol_pins(input logic [VOL_W-1:0] vol);
        logic [PIN_W-1:0] pins;
        case ((vol > VOL_MAX) ? VOL_MAX : vol)
            3'd1:    pins = PINS_AD;
            3'd2:    pins = PINS_AC;
            3'd3:    pins = PINS_BD;
            3'd4:    pins = PINS_BC;
            default: pins = PINS_OFF;
        endcase
        return pins;
    endfunction

    function automatic logic [MS_W-1:0] sat_ms(input logic [MS_W-1:0] ms);
        return (ms > MS_MAX) ? MS_MAX : ms;
    endfunction

    // 31 * ms without a multiplier
    function automatic logic [CNT_W-1:0] ms_ticks(input logic [MS_W-1:0] ms);
        logic [CNT_W-1:0] x;
        x = {{(CNT_W-MS_W){1'b0}}, ms};
        return (x << 5) - x;
    endfunction

endpackage

// ----- rtl/core/vbs_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_div
// Restoring divider, one quotient bit per cycle: TONE_CLK_HZ / divisor.
// ----------------------------------------------------------------------------
module vbs_div
    import vbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HZ_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [CNT_W-1:0]  o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [HZ_W-1:0]      r_div;
    logic [HZ_W-1:0]      r_rem;
    logic [HZ_W-1:0]      r_quo;

    logic [HZ_W:0]        trial;
    logic                 q_bit;
    logic                 last;

    always_comb begin
        trial = {r_rem, r_quo[HZ_W-1]};
        q_bit = (trial >= {1'b0, r_div});
        last  = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    end

    assign o_done     = r_busy && last;
    assign o_quotient = {{(CNT_W-HZ_W){1'b0}}, r_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !last;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
            r_quo <= TONE_CLK_HZ;
        end else if (r_busy) begin
            r_rem <= q_bit ? HZ_W'(trial - {1'b0, r_div}) : trial[HZ_W-1:0];
            r_quo <= {r_quo[HZ_W-2:0], q_bit};
        end
    end

endmodule

// ----- rtl/core/vbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_ctrl
// Item sequencing: latch, optional divide, apply, then hand off the result.
// ----------------------------------------------------------------------------
module vbs_ctrl
    import vbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.needs_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/vbs_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_dp
// Tone and phase timers, pending settings, config registers, output register.
// ----------------------------------------------------------------------------
module vbs_dp
    import vbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_status,
    input  t_in_item             i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output t_out_item            o_out_data
);

    t_in_item         r_item;
    logic [VOL_W-1:0] r_volume;
    logic             r_fluid;

    logic [CNT_W-1:0] r_tone_count,  n_tone_count;
    logic [CNT_W-1:0] r_tone_period, n_tone_period;
    logic             r_tone_running, n_tone_running;
    logic             r_oe,          n_oe;
    logic [CNT_W-1:0] r_phase_count, n_phase_count;
    logic [CNT_W-1:0] r_phase_limit, n_phase_limit;
    logic             r_phase_running, n_phase_running;
    logic             r_pulsed,      n_pulsed;
    logic             r_in_pause,    n_in_pause;
    logic [CNT_W-1:0] r_pend_period, n_pend_period;
    logic [CNT_W-1:0] r_pend_sound,  n_pend_sound;
    logic [CNT_W-1:0] r_pend_pause,  n_pend_pause;

    logic             r_out_valid;
    t_out_item        r_out_data;

    logic [HZ_W-1:0]  hz_sat;
    logic [MS_W-1:0]  len_sat;
    logic [MS_W-1:0]  pau_sat;
    logic             div_done;
    logic [CNT_W-1:0] quotient;
    logic             pulsed_now;

    vbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (hz_sat),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        hz_sat  = (r_item.tone_hz > TONE_CLK_HZ) ? TONE_CLK_HZ : r_item.tone_hz;
        len_sat = sat_ms(r_item.length_ms);
        pau_sat = sat_ms(r_item.pause_ms);
    end

    assign o_status.needs_div = ((r_item.action == ACT_UPDATE) ||
                                 (r_item.action == ACT_OVERRIDE)) && (hz_sat != '0);
    assign o_status.div_done  = div_done;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume <= VOL_RESET;
            r_fluid  <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VOLUME: r_volume <= i_cfg_data;
                REG_FLUID:  r_fluid  <= i_cfg_data[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        n_tone_count    = r_tone_count;
        n_tone_period   = r_tone_period;
        n_tone_running  = r_tone_running;
        n_oe            = r_oe;
        n_phase_count   = r_phase_count;
        n_phase_limit   = r_phase_limit;
        n_phase_running = r_phase_running;
        n_pulsed        = r_pulsed;
        n_in_pause      = r_in_pause;
        n_pend_period   = r_pend_period;
        n_pend_sound    = r_pend_sound;
        n_pend_pause    = r_pend_pause;
        pulsed_now      = r_pulsed;

        if (i_cmd.apply) begin
            case (r_item.action)
                ACT_TICK: begin
                    if (r_tone_running) begin
                        n_tone_count = (r_tone_count >= r_tone_period) ?
                                       '0 : r_tone_count + 1'b1;
                    end
                    if (r_phase_running) begin
                        if (r_phase_count >= r_phase_limit) begin
                            n_phase_count = '0;
                            if (!r_in_pause) begin
                                // sound phase over
                                n_oe = 1'b0;
                                if (r_pend_pause == '0) begin
                                    n_phase_running = 1'b0;
                                    n_pulsed        = 1'b0;
                                end else begin
                                    n_phase_limit = r_pend_pause;
                                    n_in_pause    = 1'b1;
                                end
                            end else begin
                                // pause over, pick up the pending tone
                                if (r_pend_period != '0) begin
                                    n_tone_period = r_pend_period;
                                    n_oe          = 1'b1;
                                    if (n_tone_count > r_pend_period) begin
                                        n_tone_count = '0;
                                    end
                                end
                                if (r_pend_sound == '0) begin
                                    n_phase_running = 1'b0;
                                    n_pulsed        = 1'b0;
                                end else begin
                                    n_phase_limit = r_pend_sound;
                                    n_in_pause    = 1'b0;
                                end
                            end
                        end else begin
                            n_phase_count = r_phase_count + 1'b1;
                        end
                    end
                end
                ACT_UPDATE, ACT_OVERRIDE: begin
                    if (r_item.action == ACT_OVERRIDE) begin
                        n_phase_running = 1'b0;
                        n_pend_sound    = '0;
                        n_pend_pause    = '0;
                        n_pulsed        = 1'b0;
                        pulsed_now      = 1'b0;
                    end

                    // tone
                    if (hz_sat == '0) begin
                        n_pend_period = '0;
                        if (!pulsed_now) begin
                            n_tone_running = 1'b0;
                            n_oe           = 1'b0;
                        end
                    end else begin
                        n_pend_period = quotient;
                        if (!pulsed_now || (r_fluid && !r_in_pause)) begin
                            n_tone_period = quotient;
                            n_oe          = 1'b1;
                            if (n_tone_count > quotient) begin
                                n_tone_count = '0;
                            end
                        end
                        n_tone_running = 1'b1;
                    end

                    // lengths, normal update only
                    if (r_item.action == ACT_UPDATE) begin
                        if ((len_sat == '0) || (pau_sat == '0)) begin
                            n_pend_sound = '0;
                            n_pend_pause = '0;
                        end else begin
                            n_pend_sound = ms_ticks(len_sat);
                            n_pend_pause = ms_ticks(pau_sat);
                            if (!r_pulsed) begin
                                n_phase_count   = CNT_W'(1);
                                n_tone_period   = n_pend_period;
                                n_oe            = 1'b1;
                                if (n_tone_count > n_pend_period) begin
                                    n_tone_count = '0;
                                end
                                n_phase_limit   = n_pend_sound;
                                n_phase_running = 1'b1;
                                n_in_pause      = 1'b0;
                            end
                            n_pulsed = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_count    <= '0;
            r_tone_period   <= '0;
            r_tone_running  <= 1'b0;
            r_oe            <= 1'b1;
            r_phase_count   <= '0;
            r_phase_limit   <= '0;
            r_phase_running <= 1'b0;
            r_pulsed        <= 1'b0;
            r_in_pause      <= 1'b0;
            r_pend_period   <= '0;
            r_pend_sound    <= '0;
            r_pend_pause    <= '0;
        end else begin
            r_tone_count    <= n_tone_count;
            r_tone_period   <= n_tone_period;
            r_tone_running  <= n_tone_running;
            r_oe            <= n_oe;
            r_phase_count   <= n_phase_count;
            r_phase_limit   <= n_phase_limit;
            r_phase_running <= n_phase_running;
            r_pulsed        <= n_pulsed;
            r_in_pause      <= n_in_pause;
            r_pend_period   <= n_pend_period;
            r_pend_sound    <= n_pend_sound;
            r_pend_pause    <= n_pend_pause;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data.speaker_level <= (r_tone_count < (r_tone_period >> 1));
            r_out_data.pin_drive     <= r_oe ? vol_pins(r_volume) : PINS_OFF;
            r_out_data.pause_phase   <= r_pulsed && r_in_pause;
            r_out_data.pulsed        <= r_pulsed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/vario_beep_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vario_beep_sequencer
// Buzzer tone generator with sound/pause beep sequencing, one result per item.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_stall | i_in_data   (t_in_item)
//  out     | output    | o_out_valid/ i_out_stall| o_out_data  (t_out_item)
//  cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
//  A tick or an update with zero tone goes from accept through decode, apply
//  and emit; an update or override with a nonzero tone also waits on the
//  15-step tone period divider. Results sit in an output register, so a new
//  item is taken while the last result is stalled. Sync active-low reset
//  restores volume 2 and enabled outputs. Config writes are always ready.
// ----------------------------------------------------------------------------
module vario_beep_sequencer
    import vbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    vbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vbs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- rtl/core/vbs_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vbs_chk
// Port-level checks for the beep sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module vbs_chk
    import vbs_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input t_out_item            o_out_data,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    // one transaction in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous transaction in flight");

    // silent phase is only reported inside a pulsed sequence
    a_pause_implies_pulsed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.pause_phase || o_out_data.pulsed))
        else $error("pause_phase set without pulsed");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write not taken");

endmodule

bind vario_beep_sequencer vbs_chk u_vbs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

// ----- tb/tb_vario_beep_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vario_beep_sequencer
// Self-checking bench for the beep sequencer. Tick, update and override
// transactions are predicted one by one against an in-bench model of the tone
// timer and the sound/pause sequencer. Both channels idle at random, and the
// volume and fluid-update registers are swept between phases.
// ----------------------------------------------------------------------------
module tb_vario_beep_sequencer;
    import vbs_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         TICKS_PER_MS  = 31;
    localparam int         MAX_WAIT      = 12;
    localparam int         SETTLE_CYCLES = 30;
    localparam int         CYCLE_LIMIT   = 400000;
    localparam int         TOTAL_ITEMS   = 400;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    vario_beep_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Beep model state (mirrors the block after reset)
    // ------------------------------------------------------------------------
    logic [VOL_W-1:0] vol_reg      = VOL_RESET;
    logic             fluid_reg    = 1'b0;
    logic [CNT_W-1:0] tone_cnt     = '0;
    logic [CNT_W-1:0] tone_per     = '0;
    logic             tone_on      = 1'b0;
    logic             pins_en      = 1'b1;
    logic [CNT_W-1:0] ph_cnt       = '0;
    logic [CNT_W-1:0] ph_lim       = '0;
    logic             ph_on        = 1'b0;
    logic             beeping      = 1'b0;
    logic             silent_half  = 1'b0;
    logic [CNT_W-1:0] next_per     = '0;
    logic [CNT_W-1:0] next_sound   = '0;
    logic [CNT_W-1:0] next_silence = '0;

    t_out_item beep_expect_q[$];
    int        fail_count    = 0;
    int        items_sent    = 0;
    int        cycle_count   = 0;
    int        rx_hold_cycles = 0;
    int        rx_wait       = 0;
    bit        tx_calm       = 1'b0;
    bit        rx_calm       = 1'b0;

    function automatic void tone_apply(input logic [CNT_W-1:0] p);
        tone_per = p;
        pins_en  = 1'b1;
        if (tone_cnt > p)
            tone_cnt = '0;
    endfunction

    function automatic void tone_update(input logic [HZ_W-1:0] hz_in);
        logic [HZ_W-1:0] hz;
        hz = (hz_in > TONE_CLK_HZ) ? TONE_CLK_HZ : hz_in;
        if (hz == 0) begin
            next_per = '0;
            if (!beeping) begin
                tone_on = 1'b0;
                pins_en = 1'b0;
            end
        end else begin
            next_per = CNT_W'(TONE_CLK_HZ / hz);
            if (!beeping)
                tone_apply(next_per);
            if (fluid_reg && !silent_half)
                tone_apply(next_per);
            tone_on = 1'b1;
        end
    endfunction

    function automatic void lengths_set(input logic [MS_W-1:0] len_in,
                                        input logic [MS_W-1:0] pau_in);
        logic [MS_W-1:0] len;
        logic [MS_W-1:0] pau;
        len = (len_in > MS_MAX) ? MS_MAX : len_in;
        pau = (pau_in > MS_MAX) ? MS_MAX : pau_in;
        if (len == 0 || pau == 0) begin
            next_sound   = '0;
            next_silence = '0;
            return;
        end
        next_sound   = CNT_W'(len * TICKS_PER_MS);
        next_silence = CNT_W'(pau * TICKS_PER_MS);
        if (!beeping) begin
            ph_cnt      = CNT_W'(1);
            tone_apply(next_per);
            ph_lim      = next_sound;
            ph_on       = 1'b1;
            silent_half = 1'b0;
        end
        beeping = 1'b1;
    endfunction

    function automatic t_out_item predict_beep(input t_in_item it);
        t_out_item        res;
        logic [VOL_W-1:0] vol;
        case (it.action)
            ACT_TICK: begin
                if (tone_on)
                    tone_cnt = (tone_cnt >= tone_per) ? '0 : tone_cnt + 1'b1;
                if (ph_on) begin
                    if (ph_cnt >= ph_lim) begin
                        ph_cnt = '0;
                        if (!silent_half) begin
                            // sound over: go silent, or stop if no pause left
                            pins_en = 1'b0;
                            if (next_silence == 0) begin
                                ph_on   = 1'b0;
                                beeping = 1'b0;
                            end else begin
                                ph_lim      = next_silence;
                                silent_half = 1'b1;
                            end
                        end else begin
                            if (next_per != 0)
                                tone_apply(next_per);
                            if (next_sound == 0) begin
                                ph_on   = 1'b0;
                                beeping = 1'b0;
                            end else begin
                                ph_lim      = next_sound;
                                silent_half = 1'b0;
                            end
                        end
                    end else begin
                        ph_cnt = ph_cnt + 1'b1;
                    end
                end
            end
            ACT_UPDATE: begin
                tone_update(it.tone_hz);
                lengths_set(it.length_ms, it.pause_ms);
            end
            ACT_OVERRIDE: begin
                ph_on = 1'b0;
                lengths_set('0, '0);
                beeping = 1'b0;
                tone_update(it.tone_hz);
            end
            default: ;
        endcase

        vol = (vol_reg > VOL_MAX) ? VOL_MAX : vol_reg;
        case (vol)
            3'd1:    res.pin_drive = PINS_AD;
            3'd2:    res.pin_drive = PINS_AC;
            3'd3:    res.pin_drive = PINS_BD;
            3'd4:    res.pin_drive = PINS_BC;
            default: res.pin_drive = PINS_OFF;
        endcase
        if (!pins_en)
            res.pin_drive = PINS_OFF;
        res.speaker_level = (tone_cnt < (tone_per >> 1));
        res.pause_phase   = beeping && silent_half;
        res.pulsed        = beeping;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(input logic [1:0] act,
                                           input logic [HZ_W-1:0] hz,
                                           input logic [MS_W-1:0] len,
                                           input logic [MS_W-1:0] pau);
        t_in_item it;
        it.action    = act;
        it.tone_hz   = hz;
        it.length_ms = len;
        it.pause_ms  = pau;
        return it;
    endfunction

    // mostly short tone periods so the PWM level actually toggles
    function automatic logic [HZ_W-1:0] pick_hz();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return HZ_W'($urandom_range(31251, 32767));
            2, 3:    return HZ_W'($urandom_range(1, 999));
            default: return HZ_W'($urandom_range(1000, 31250));
        endcase
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        case ($urandom_range(0, 9))
            0, 1:    it.action = ACT_UPDATE;
            2, 3:    it.action = ACT_OVERRIDE;
            4:       it.action = ACT_UNUSED;
            default: it.action = ACT_TICK;
        endcase
        it.tone_hz   = $urandom_range(0, 1) ? HZ_W'($urandom()) : pick_hz();
        it.length_ms = $urandom_range(0, 1) ? MS_W'($urandom()) : MS_W'($urandom_range(0, 3));
        it.pause_ms  = $urandom_range(0, 1) ? MS_W'($urandom()) : MS_W'($urandom_range(0, 3));
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        beep_expect_q.push_back(predict_beep(it));
        items_sent++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (beep_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_VOLUME)
            vol_reg = val;
        else if (idx == REG_FLUID)
            fluid_reg = val[0];
    endtask

    // restart from a clean continuous tone, then a short beep pattern with
    // occasional retunes, length changes and clears while it runs
    task automatic run_beep_sequence(input int n_ticks, input int churn);
        send_item(make_item(ACT_OVERRIDE, pick_hz(), '0, '0));
        send_item(make_item(ACT_UPDATE, pick_hz(), MS_W'($urandom_range(1, 3)),
                            MS_W'($urandom_range(1, 3))));
        repeat (n_ticks) begin
            if ($urandom_range(1, churn) == 1)
                send_item(make_item(ACT_UPDATE, pick_hz(),
                                    $urandom_range(0, 1) ? '0 :
                                        MS_W'($urandom_range(1, 3)),
                                    MS_W'($urandom_range(0, 3))));
            else
                send_item(make_item(ACT_TICK, '0, '0, '0));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stall pattern and checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_stall <= 1'b1;
        end else begin
            if (o_out_valid && !i_out_stall)
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            else if (rx_wait > 0)
                rx_wait--;
            i_out_stall <= (rx_wait > 0);
        end
    end

    task automatic check_field(input string name, input logic [PIN_W-1:0] want,
                               input logic [PIN_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (beep_expect_q.size() == 0) begin
                $display("%0t ns: unexpected transaction, expected none, actual %p",
                         $time, o_out_data);
                fail_count++;
            end else begin
                want = beep_expect_q.pop_front();
                check_field("speaker_level", PIN_W'(want.speaker_level),
                            PIN_W'(o_out_data.speaker_level));
                check_field("pin_drive", want.pin_drive, o_out_data.pin_drive);
                check_field("pause_phase", PIN_W'(want.pause_phase),
                            PIN_W'(o_out_data.pause_phase));
                check_field("pulsed", PIN_W'(want.pulsed), PIN_W'(o_out_data.pulsed));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d transactions outstanding",
                     $time, beep_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_UNUSED, '1, '1, '1));
        send_item(make_item(ACT_TICK, '1, '1, '1));
    endtask

    task automatic test_directed_extremes();
        send_item(make_item(ACT_UPDATE, '0, '0, '0));
        send_item(make_item(ACT_UPDATE, TONE_CLK_HZ, '0, '0));
        send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_UPDATE, 15'd7813, '0, 12'd5));
        repeat (4) send_item(make_item(ACT_TICK, '0, '0, '0));
        // saturating tone and lengths start a pulsed sequence
        send_item(make_item(ACT_UPDATE, '1, '1, '1));
        send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_UNUSED, '0, '0, '0));
        send_item(make_item(ACT_OVERRIDE, 15'd1, '0, '0));
        send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_OVERRIDE, '0, '1, '1));
        send_item(make_item(ACT_TICK, '0, '0, '0));
        // pulsed start with zero tone: zero period, output stays low
        send_item(make_item(ACT_UPDATE, '0, 12'd1, 12'd1));
        send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_UPDATE, 15'd5000, 12'd1, '0));
        send_item(make_item(ACT_OVERRIDE, 15'd31249, MS_MAX, MS_MAX));
        send_item(make_item(ACT_UPDATE, 15'd20000, 12'd2114, 12'd1));
        send_item(make_item(ACT_OVERRIDE, 15'd3000, '0, '0));
    endtask

    task automatic test_beep_sequences();
        int k;
        // lengths cleared mid-sound: the phase runs out and the sequence stops
        send_item(make_item(ACT_OVERRIDE, 15'd6000, '0, '0));
        send_item(make_item(ACT_UPDATE, 15'd4000, 12'd1, 12'd1));
        repeat (10) send_item(make_item(ACT_TICK, '0, '0, '0));
        send_item(make_item(ACT_UPDATE, 15'd9000, '0, '0));
        for (k = 0; k < 30; k++)
            send_item(make_item(ACT_TICK, '0, '0, '0));
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_beep_sequence(40, 30);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        run_beep_sequence(40, 15);
    endtask

    task automatic test_volume_and_fluid();
        int v;
        for (v = 0; v < 8; v++) begin
            write_reg(REG_VOLUME, CFG_DAT_W'(v));
            write_reg(REG_FLUID, v[0] ? 3'd1 : 3'd0);
            run_beep_sequence(10, 5);
        end
        write_reg(REG_VOLUME, VOL_RESET);
        write_reg(REG_FLUID, 3'd1);
    endtask

    task automatic test_output_backpressure();
        tx_calm = 1'b1;
        rx_hold_cycles = 250;
        repeat (20) send_item(noise_item());
        tx_calm = 1'b0;
    endtask

    task automatic test_sender_pause();
        repeat (8) send_item(noise_item());
        wait_drained();
        repeat (8) send_item(noise_item());
    endtask

    task automatic test_random_mix(input int stop_at);
        while (items_sent < stop_at) begin
            tx_calm = ($urandom_range(0, 5) == 0);
            rx_calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) != 0)
                run_beep_sequence($urandom_range(10, 40), $urandom_range(8, 40));
            else
                repeat ($urandom_range(1, 8)) send_item(noise_item());
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_directed_extremes();
        test_beep_sequences();
        test_volume_and_fluid();
        test_output_backpressure();
        test_sender_pause();
        test_random_mix(TOTAL_ITEMS - 60);
        write_reg(REG_FLUID, 3'd0);
        test_random_mix(TOTAL_ITEMS);

        wait_drained();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
